FILE: src/etf_pkg.sv
// Shared types, constants and saturation helpers for the escape-time fractal pixel core.
package etf_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 28;
   localparam int COUNT_BITS = 16;
   localparam int WORD_BITS  = FRAC_BITS + 4;
   localparam int MUL_BITS   = (WORD_BITS > 32) ? WORD_BITS : 32;
   localparam int PROD_BITS  = 2 * MUL_BITS;

   localparam int EDGE_BITS      = 32;
   localparam int STEP_BITS      = 31;
   localparam int LIMIT_BITS     = 16;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic signed [EDGE_BITS-1:0] LEFT_EDGE_RESET  = 32'shE000_0000;
   localparam logic signed [EDGE_BITS-1:0] TOP_EDGE_RESET   = 32'sh1000_0000;
   localparam logic [STEP_BITS-1:0]        COLUMN_STEP_RESET = 31'd786432;
   localparam logic [STEP_BITS-1:0]        ROW_STEP_RESET    = 31'd524288;
   localparam logic [LIMIT_BITS-1:0]       LIMIT_RESET       = 16'd256;

   // Largest and smallest word value, held at product width.
   localparam logic signed [PROD_BITS-1:0] PROD_WORD_MAX =
      {{(PROD_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [PROD_BITS-1:0] PROD_WORD_MIN = ~PROD_WORD_MAX;

   // Escape threshold 4.0 at the scale of a full-width square.
   localparam logic [PROD_BITS:0] ESCAPE_LIMIT = (PROD_BITS+1)'(1) << (2*FRAC_BITS + 2);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEFT_EDGE       = 3'd0,
      CSR_TOP_EDGE        = 3'd1,
      CSR_COLUMN_STEP     = 3'd2,
      CSR_ROW_STEP        = 3'd3,
      CSR_ITERATION_LIMIT = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_C_RE,
      ST_C_IM,
      ST_C_SET,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] iteration_count;
      logic                  inside_set;
   } rsp_type;

   // Clamp a full-width value to the word range.
   function automatic logic signed [WORD_BITS-1:0] sat_prod(
      input logic signed [PROD_BITS-1:0] v);
      logic signed [WORD_BITS-1:0] r;
      if (v > PROD_WORD_MAX) begin
         r = PROD_WORD_MAX[WORD_BITS-1:0];
      end else if (v < PROD_WORD_MIN) begin
         r = PROD_WORD_MIN[WORD_BITS-1:0];
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

   // Add two words and clamp the sum to the word range.
   function automatic logic signed [WORD_BITS-1:0] sat_add(
      input logic signed [WORD_BITS-1:0] a,
      input logic signed [WORD_BITS-1:0] b);
      logic signed [WORD_BITS:0]   s;
      logic signed [WORD_BITS-1:0] r;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         r = {s[WORD_BITS], {(WORD_BITS-1){~s[WORD_BITS]}}};
      end else begin
         r = s[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/escape_time_fractal_pixel_core.sv
// Top level of the escape-time fractal pixel core: registers, sequencer and datapath.
//
//   channel   ports                          direction   flow
//   request   start, busy, req_data          in          taken when start and not busy
//   result    rsp_valid, rsp_data            out         one-cycle strobe, no stall
//   csr       csr_wr_en, csr_index, csr_wdata in         written on any edge with wr_en
//
// Setup forms c in states C_RE, C_IM and C_SET; every iteration then makes three passes through
// the single shared multiplier plus an update state, so that unit sets the rate. A pixel inside
// the set runs every iteration up to the limit, which defaults to 256.
// Reset is synchronous and returns the registers to their default view of the plane.
// The block is busy for the whole pixel; the result is a single beat that must be taken.
module escape_time_fractal_pixel_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  etf_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   output etf_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [etf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [etf_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int W = etf_pkg::WORD_BITS;
   localparam int P = etf_pkg::PROD_BITS;
   localparam int M = etf_pkg::MUL_BITS;

   logic signed [etf_pkg::EDGE_BITS-1:0]  left_edge_ff;
   logic signed [etf_pkg::EDGE_BITS-1:0]  top_edge_ff;
   logic [etf_pkg::STEP_BITS-1:0]         column_step_ff;
   logic [etf_pkg::STEP_BITS-1:0]         row_step_ff;
   logic [etf_pkg::COUNT_BITS-1:0]        limit_ff;

   etf_pkg::state_type                    state_ff, state_in;
   logic [etf_pkg::COORD_BITS-1:0]        column_ff, column_in;
   logic [etf_pkg::COORD_BITS-1:0]        row_ff, row_in;
   logic signed [W-1:0]                   cre_ff, cre_in;
   logic signed [W-1:0]                   cim_ff, cim_in;
   logic signed [W-1:0]                   re_ff, re_in;
   logic signed [W-1:0]                   im_ff, im_in;
   logic signed [P-1:0]                   re2_ff, re2_in;
   logic signed [P-1:0]                   diff_ff, diff_in;
   logic [etf_pkg::COUNT_BITS-1:0]        iter_ff, iter_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   etf_pkg::rsp_type                      rsp_data_ff, rsp_data_in;

   logic signed [M-1:0]                   op_a;
   logic signed [M-1:0]                   op_b;
   logic signed [P-1:0]                   prod;
   logic [P:0]                            mag;
   logic signed [P-1:0]                   cross_shift;
   logic signed [P-1:0]                   diff_shift;

   etf_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_edge_ff   <= etf_pkg::LEFT_EDGE_RESET;
         top_edge_ff    <= etf_pkg::TOP_EDGE_RESET;
         column_step_ff <= etf_pkg::COLUMN_STEP_RESET;
         row_step_ff    <= etf_pkg::ROW_STEP_RESET;
         limit_ff       <= etf_pkg::COUNT_BITS'(etf_pkg::LIMIT_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            etf_pkg::CSR_LEFT_EDGE: begin
               left_edge_ff <= csr_wdata[etf_pkg::EDGE_BITS-1:0];
            end
            etf_pkg::CSR_TOP_EDGE: begin
               top_edge_ff <= csr_wdata[etf_pkg::EDGE_BITS-1:0];
            end
            etf_pkg::CSR_COLUMN_STEP: begin
               column_step_ff <= csr_wdata[etf_pkg::STEP_BITS-1:0];
            end
            etf_pkg::CSR_ROW_STEP: begin
               row_step_ff <= csr_wdata[etf_pkg::STEP_BITS-1:0];
            end
            etf_pkg::CSR_ITERATION_LIMIT: begin
               limit_ff <= etf_pkg::COUNT_BITS'(csr_wdata[etf_pkg::LIMIT_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff   <= column_in;
      row_ff      <= row_in;
      cre_ff      <= cre_in;
      cim_ff      <= cim_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      re2_ff      <= re2_in;
      diff_ff     <= diff_in;
      iter_ff     <= iter_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The product register holds |im|^2 in the cross state, so the magnitude is formed there.
   assign mag         = {1'b0, re2_ff} + {1'b0, prod};
   assign cross_shift = prod >>> (etf_pkg::FRAC_BITS - 1);
   assign diff_shift  = diff_ff >>> etf_pkg::FRAC_BITS;

   always_comb begin
      state_in     = state_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      re2_in       = re2_ff;
      diff_in      = diff_ff;
      iter_in      = iter_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      op_a         = M'(re_ff);
      op_b         = M'(re_ff);

      unique case (state_ff)
         etf_pkg::ST_IDLE: begin
            if (start) begin
               column_in = req_data.column;
               row_in    = req_data.pixel_row;
               state_in  = etf_pkg::ST_C_RE;
            end
         end
         etf_pkg::ST_C_RE: begin
            op_a     = $signed(M'(column_ff));
            op_b     = $signed(M'(column_step_ff));
            state_in = etf_pkg::ST_C_IM;
         end
         etf_pkg::ST_C_IM: begin
            cre_in   = etf_pkg::sat_prod(P'(left_edge_ff) + prod);
            op_a     = $signed(M'(row_ff));
            op_b     = $signed(M'(row_step_ff));
            state_in = etf_pkg::ST_C_SET;
         end
         etf_pkg::ST_C_SET: begin
            cim_in   = etf_pkg::sat_prod(P'(top_edge_ff) - prod);
            re_in    = cre_ff;
            im_in    = cim_in;
            iter_in  = '0;
            state_in = etf_pkg::ST_SQ_RE;
         end
         etf_pkg::ST_SQ_RE: begin
            if (iter_ff == limit_ff) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.iteration_count = iter_ff;
               rsp_data_in.inside_set      = 1'b1;
               state_in                    = etf_pkg::ST_IDLE;
            end else begin
               op_a     = M'(re_ff);
               op_b     = M'(re_ff);
               state_in = etf_pkg::ST_SQ_IM;
            end
         end
         etf_pkg::ST_SQ_IM: begin
            re2_in   = prod;
            op_a     = M'(im_ff);
            op_b     = M'(im_ff);
            state_in = etf_pkg::ST_CROSS;
         end
         etf_pkg::ST_CROSS: begin
            if (mag > etf_pkg::ESCAPE_LIMIT) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.iteration_count = iter_ff;
               rsp_data_in.inside_set      = (iter_ff == limit_ff);
               state_in                    = etf_pkg::ST_IDLE;
            end else begin
               diff_in  = re2_ff - prod;
               op_a     = M'(re_ff);
               op_b     = M'(im_ff);
               state_in = etf_pkg::ST_UPDATE;
            end
         end
         etf_pkg::ST_UPDATE: begin
            im_in    = etf_pkg::sat_add(etf_pkg::sat_prod(cross_shift), cim_ff);
            re_in    = etf_pkg::sat_add(etf_pkg::sat_prod(diff_shift), cre_ff);
            iter_in  = iter_ff + 1'b1;
            state_in = etf_pkg::ST_SQ_RE;
         end
         default: begin
            state_in = etf_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != etf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/etf_mul.sv
// Shared signed multiplier with a registered product.
module etf_mul (
   input  logic                                  clock,
   input  logic signed [etf_pkg::MUL_BITS-1:0]   op_a,
   input  logic signed [etf_pkg::MUL_BITS-1:0]   op_b,
   output logic signed [etf_pkg::PROD_BITS-1:0]  prod
);

   logic signed [etf_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [etf_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = etf_pkg::PROD_BITS'(op_a) * etf_pkg::PROD_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: src/etf_checker.sv
// Port-level checks on the escape-time fractal pixel core, bound to the top level.
module etf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input etf_pkg::rsp_type  rsp_data
);

   // An accepted pixel keeps the core busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accepting a pixel");

   // The result beat appears as the core goes idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while still busy");

   // A result only ever closes a pixel that was in progress.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a pixel in progress");

   // Each pixel gives a single one-cycle beat.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // No result beat comes straight after acceptance: even a zero limit, which reports inside
   // with a zero count, first passes through the setup states C_RE, C_IM and C_SET.
   a_rsp_not_early: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid ##1 !rsp_valid)
      else $error("result beat too soon after acceptance");

endmodule

bind escape_time_fractal_pixel_core etf_checker u_etf_checker (.*);

FILE: sim/escape_time_fractal_pixel_core_tb.sv
// Self-checking testbench for the escape-time fractal pixel core: predictor, driver and monitor.
`timescale 1ns / 1ps

module escape_time_fractal_pixel_core_tb;

   localparam int W = etf_pkg::WORD_BITS;
   localparam longint WORD_TOP    = (longint'(1) <<< (W - 1)) - 1;
   localparam longint WORD_BOTTOM = -WORD_TOP - 1;
   localparam logic signed [127:0] ESCAPE_MAG = 128'sd4 <<< (2 * etf_pkg::FRAC_BITS);
   localparam int unsigned COORD_TOP = (1 << etf_pkg::COORD_BITS) - 1;
   localparam int unsigned PIXELS_PER_SWEEP = 75;
   localparam int unsigned SWEEPS = 10;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   etf_pkg::req_type                    req_data = '0;
   logic                                rsp_valid;
   etf_pkg::rsp_type                    rsp_data;
   logic                                csr_wr_en = 1'b0;
   logic [etf_pkg::CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [etf_pkg::CSR_DATA_BITS-1:0]   csr_wdata = '0;

   // Our own copy of the view registers.
   logic signed [etf_pkg::EDGE_BITS-1:0] view_left  = etf_pkg::LEFT_EDGE_RESET;
   logic signed [etf_pkg::EDGE_BITS-1:0] view_top   = etf_pkg::TOP_EDGE_RESET;
   logic [etf_pkg::STEP_BITS-1:0]        col_pitch  = etf_pkg::COLUMN_STEP_RESET;
   logic [etf_pkg::STEP_BITS-1:0]        row_pitch  = etf_pkg::ROW_STEP_RESET;
   logic [etf_pkg::LIMIT_BITS-1:0]       iter_cap   = etf_pkg::LIMIT_RESET;

   etf_pkg::req_type pixel_backlog[$];
   etf_pkg::rsp_type expected_pixels[$];
   etf_pkg::rsp_type oldest_pixel;
   bit               offer_open = 1'b0;
   bit               sender_idles = 1'b1;
   int unsigned      gap_left = 0;
   int unsigned      fail_count = 0;

   escape_time_fractal_pixel_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [W-1:0] word_clamp(longint v);
      longint t;
      t = (v > WORD_TOP) ? WORD_TOP : ((v < WORD_BOTTOM) ? WORD_BOTTOM : v);
      return t[W-1:0];
   endfunction

   function automatic longint wide_clamp(logic signed [127:0] v);
      longint t;
      if (v > WORD_TOP) begin
         t = WORD_TOP;
      end else if (v < WORD_BOTTOM) begin
         t = WORD_BOTTOM;
      end else begin
         t = longint'(v[63:0]);
      end
      return t;
   endfunction

   // Escape index of one pixel under the current view.
   function automatic etf_pkg::rsp_type predict_escape(etf_pkg::req_type px);
      longint              re_pos;
      longint              im_pos;
      logic signed [W-1:0] c_re, c_im, z_re, z_im;
      logic signed [127:0] w_re, w_im, re_sq, im_sq, cross_term;
      int unsigned         cap;
      int unsigned         n;
      bit                  escaped;
      etf_pkg::rsp_type    r;
      re_pos = longint'(view_left) + longint'(px.column) * longint'(col_pitch);
      im_pos = longint'(view_top) - longint'(px.pixel_row) * longint'(row_pitch);
      c_re = word_clamp(re_pos);
      c_im = word_clamp(im_pos);
      z_re = c_re;
      z_im = c_im;
      cap = iter_cap;
      n = 0;
      escaped = 1'b0;
      while (!escaped && n < cap) begin
         w_re = z_re;
         w_im = z_im;
         re_sq = w_re * w_re;
         im_sq = w_im * w_im;
         // Equality with 4.0 does not count as an escape.
         if (re_sq + im_sq > ESCAPE_MAG) begin
            escaped = 1'b1;
         end else begin
            cross_term = w_re * w_im;
            z_im = word_clamp(wide_clamp(cross_term >>> (etf_pkg::FRAC_BITS - 1))
                              + longint'(c_im));
            z_re = word_clamp(wide_clamp((re_sq - im_sq) >>> etf_pkg::FRAC_BITS)
                              + longint'(c_re));
            n++;
         end
      end
      r.iteration_count = n[etf_pkg::COUNT_BITS-1:0];
      r.inside_set = (n == cap);
      return r;
   endfunction

   function automatic int unsigned next_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!sender_idles || roll < 50) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 80);
   endfunction

   function automatic int unsigned pick_coord(int unsigned span);
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(0, COORD_TOP);
      end
      return $urandom_range(0, span);
   endfunction

   // Driver: a beat stays offered until the core takes it.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!offer_open) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pixel_backlog.size() > 0) begin
            req_data <= pixel_backlog.pop_front();
            start <= 1'b1;
            offer_open = 1'b1;
            gap_left = next_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: results are checked before a beat taken at the same edge is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("result beat with no pixel outstanding: count %0d, inside %0d",
                      rsp_data.iteration_count, rsp_data.inside_set);
               fail_count++;
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               if (rsp_data.iteration_count !== oldest_pixel.iteration_count) begin
                  $error("iteration_count: expected %0d, actual %0d",
                         oldest_pixel.iteration_count, rsp_data.iteration_count);
                  fail_count++;
               end
               if (rsp_data.inside_set !== oldest_pixel.inside_set) begin
                  $error("inside_set: expected %0d, actual %0d",
                         oldest_pixel.inside_set, rsp_data.inside_set);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_pixels.insert(expected_pixels.size(), predict_escape(req_data));
            offer_open = 1'b0;
         end
      end
   end

   task automatic queue_pixel(int unsigned col, int unsigned row);
      etf_pkg::req_type px;
      px.column = col[etf_pkg::COORD_BITS-1:0];
      px.pixel_row = row[etf_pkg::COORD_BITS-1:0];
      pixel_backlog.insert(pixel_backlog.size(), px);
   endtask

   // Returns at a falling edge once every beat is taken and answered.
   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || offer_open || expected_pixels.size() != 0
             || start || busy) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(logic [etf_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [etf_pkg::CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         etf_pkg::CSR_LEFT_EDGE:       view_left = data;
         etf_pkg::CSR_TOP_EDGE:        view_top = data;
         etf_pkg::CSR_COLUMN_STEP:     col_pitch = data[etf_pkg::STEP_BITS-1:0];
         etf_pkg::CSR_ROW_STEP:        row_pitch = data[etf_pkg::STEP_BITS-1:0];
         etf_pkg::CSR_ITERATION_LIMIT: iter_cap = data[etf_pkg::LIMIT_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_view(logic [31:0] left, logic [31:0] top, logic [31:0] col_step,
                            logic [31:0] row_step, logic [31:0] limit, bit junk);
      wait_drained();
      write_csr(etf_pkg::CSR_LEFT_EDGE, left);
      write_csr(etf_pkg::CSR_TOP_EDGE, top);
      write_csr(etf_pkg::CSR_COLUMN_STEP, col_step);
      write_csr(etf_pkg::CSR_ROW_STEP, row_step);
      write_csr(etf_pkg::CSR_ITERATION_LIMIT, limit);
      // A write to an unused index must leave every register alone.
      if (junk) begin
         write_csr(etf_pkg::CSR_INDEX_BITS'($urandom_range(etf_pkg::CSR_ITERATION_LIMIT + 1,
                                           (1 << etf_pkg::CSR_INDEX_BITS) - 1)), $urandom);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned span;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default view: corner escapes at once, far corner saturates, center stays inside.
      queue_pixel(0, 0);
      queue_pixel(COORD_TOP, COORD_TOP);
      queue_pixel(512, 512);
      queue_pixel(12'hAAA, 12'h555);
      queue_pixel(12'h555, 12'hAAA);
      queue_pixel(700, 300);

      // Edges and steps at their extremes with the smallest nonzero limit.
      load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1'b0);
      queue_pixel(0, 0);
      queue_pixel(1, 1);
      queue_pixel(COORD_TOP, 0);
      load_view(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1, 1'b1);
      queue_pixel(COORD_TOP, COORD_TOP);
      queue_pixel(0, 0);

      // Origin with a zero limit, a limit of one, and the largest limit.
      load_view(0, 0, 0, 0, 0, 1'b0);
      queue_pixel(0, 0);
      queue_pixel(COORD_TOP, COORD_TOP);
      load_view(0, 0, 0, 0, 1, 1'b0);
      queue_pixel(7, 9);
      load_view(0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
      queue_pixel(0, 0);

      // Magnitude exactly 4: -2 never escapes, 2 and -2i escape one step later.
      load_view(32'hE000_0000, 0, 32'h2000_0000, 32'h2000_0000, 20, 1'b1);
      queue_pixel(0, 0);
      queue_pixel(2, 0);
      queue_pixel(1, 1);
      queue_pixel(1, 0);

      for (int sweep = 0; sweep < SWEEPS; sweep++) begin
         if ($urandom_range(0, 9) < 7) begin
            // A window around the set where escape counts vary.
            load_view(-671088640 + $urandom_range(0, 1 << 29),
                      134217728 + $urandom_range(0, 1 << 28),
                      {1'($urandom_range(0, 1)), 31'($urandom_range(1 << 19, 1 << 23))},
                      {1'($urandom_range(0, 1)), 31'($urandom_range(1 << 19, 1 << 23))},
                      {16'($urandom), 16'($urandom_range(2, 64))},
                      1'($urandom_range(0, 1)));
            span = 127;
         end else begin
            load_view($urandom, $urandom, $urandom >> $urandom_range(0, 31),
                      $urandom >> $urandom_range(0, 31),
                      {16'($urandom), 16'($urandom_range(1, 40))},
                      1'($urandom_range(0, 1)));
            span = COORD_TOP;
         end
         sender_idles = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < PIXELS_PER_SWEEP; k++) begin
            queue_pixel(pick_coord(span), pick_coord(span));
         end
      end

      wait_drained();
      repeat (16) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
src/etf_pkg.sv
src/etf_mul.sv
src/escape_time_fractal_pixel_core.sv
src/etf_checker.sv
sim/escape_time_fractal_pixel_core_tb.sv
